// ----- hdl/three_level_priority_queue_assert.svh -----
// ----------------------------------------------------------------------------
// three_level_priority_queue assertion macros
// concurrent checks on clk_i, with the asynchronous reset masking them
// ----------------------------------------------------------------------------
`ifndef THREE_LEVEL_PRIORITY_QUEUE_ASSERT_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property must hold at every edge outside reset
`define TLPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// condition must never be seen outside reset
`define TLPQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define TLPQ_ASSERT(lbl, prop, msg)
`define TLPQ_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- hdl/tlpq_pkg.sv -----
// ----------------------------------------------------------------------------
// tlpq_pkg
// types, character constants and the level classifier of the priority queue
// ----------------------------------------------------------------------------
package tlpq_pkg;

  localparam int NUM_LEVELS = 3;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef logic [1:0] level_t;

  localparam level_t LVL_HIGH = 2'd0;
  localparam level_t LVL_MID  = 2'd1;
  localparam level_t LVL_LOW  = 2'd2;
  localparam level_t LVL_NONE = 2'd3;

  // ascii constants
  localparam logic [7:0] CH_UP_A     = 8'h41;
  localparam logic [7:0] CH_UP_C     = 8'h43;
  localparam logic [7:0] CH_UP_D     = 8'h44;
  localparam logic [7:0] CH_UP_F     = 8'h46;
  localparam logic [7:0] CH_UP_G     = 8'h47;
  localparam logic [7:0] CH_UP_I     = 8'h49;
  localparam logic [7:0] CH_LO_A     = 8'h61;
  localparam logic [7:0] CH_LO_I     = 8'h69;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] CH_EMPTY    = 8'h78;
  localparam logic [7:0] CH_NONE     = 8'h00;

  // request held while its store read is in flight
  typedef struct packed {
    status_e status;
    level_t  level;
    logic    hit;
  } tlpq_meta_t;

  // map a character to its level, LVL_NONE when it has none
  function automatic level_t classify(logic [7:0] ch);
    logic [7:0] up;
    level_t     lvl;
    up = (ch inside {[CH_LO_A:CH_LO_I]}) ? (ch - CASE_OFFSET) : ch;
    if (up inside {[CH_UP_A:CH_UP_C]}) begin
      lvl = LVL_HIGH;
    end else if (up inside {[CH_UP_D:CH_UP_F]}) begin
      lvl = LVL_MID;
    end else if (up inside {[CH_UP_G:CH_UP_I]}) begin
      lvl = LVL_LOW;
    end else begin
      lvl = LVL_NONE;
    end
    return lvl;
  endfunction

endpackage

// ----- hdl/tlpq_ram.sv -----
// ----------------------------------------------------------------------------
// tlpq_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module tlpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/three_level_priority_queue.sv -----
// ----------------------------------------------------------------------------
// three_level_priority_queue
// A request passes the read stage register and then the output register.
// Throughput: one request per cycle while the result side does not stall; the store ram has one write and one read
// port and each request uses at most one of them.
// Reset: pointers and fill counts clear to zero, all levels empty; the store
// itself is not cleared and needs no pass after reset.
// Three circular fifos of characters share one ram, one bank per level.
// ----------------------------------------------------------------------------
module three_level_priority_queue #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_in
  input  logic        s_axis_tuser_i,   // [0] kind: 0 enqueue, 1 dequeue
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [1:0] status, [9:2] char_out,
                                        // [11:10] level, [15:12] zero
);

  import tlpq_pkg::*;

  `include "three_level_priority_queue_assert.svh"

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_D  = NUM_LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(RAM_D);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [PTR_W-1:0] head_q [NUM_LEVELS];
  logic [PTR_W-1:0] head_d [NUM_LEVELS];
  logic [PTR_W-1:0] tail_q [NUM_LEVELS];
  logic [PTR_W-1:0] tail_d [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_q  [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_d  [NUM_LEVELS];

  logic             s_xfer;
  logic             is_deq;
  logic [7:0]       char_in;
  level_t           cls;
  level_t           sel_lvl;
  logic             found;
  status_e          req_status;
  logic [PTR_W-1:0] sel_head;
  logic [PTR_W-1:0] sel_tail;
  logic [CNT_W-1:0] sel_cnt;
  logic             ram_we;
  logic             ram_re;
  logic [ADDR_W-1:0] lvl_base;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  tlpq_meta_t       s1_d;
  tlpq_meta_t       s1_q;
  logic             s1_valid_q;
  logic             s1_adv;

  logic             out_valid_q;
  status_e          out_status_q;
  logic [7:0]       out_char_q;
  logic [7:0]       out_char_d;
  level_t           out_level_q;

  // input transfer and decode
  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_deq          = s_axis_tuser_i;
  assign char_in         = s_axis_tdata_i;
  assign cls             = classify(char_in);

  // level selection: class on enqueue, first non-empty level on dequeue
  always_comb begin
    found   = 1'b0;
    sel_lvl = LVL_HIGH;
    if (is_deq) begin
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
        if (cnt_q[l] != '0) begin
          found   = 1'b1;
          sel_lvl = level_t'(l);
        end
      end
    end else if (cls != LVL_NONE) begin
      sel_lvl = cls;
    end
  end

  // pointers and count of the selected level
  always_comb begin
    sel_head = '0;
    sel_tail = '0;
    sel_cnt  = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (sel_lvl == level_t'(l)) begin
        sel_head = head_q[l];
        sel_tail = tail_q[l];
        sel_cnt  = cnt_q[l];
      end
    end
  end

  // request status
  always_comb begin
    if (is_deq) begin
      req_status = found ? ST_OK : ST_EMPTY;
    end else if (cls == LVL_NONE) begin
      req_status = ST_INVALID;
    end else if (sel_cnt == CNT_FULL) begin
      req_status = ST_FULL;
    end else begin
      req_status = ST_OK;
    end
  end

  // store access
  assign ram_we    = s_xfer && !is_deq && (req_status == ST_OK);
  assign ram_re    = s_xfer && is_deq && found;
  assign lvl_base  = ADDR_W'(sel_lvl) * ADDR_W'(QUEUE_DEPTH);
  assign ram_waddr = lvl_base + ADDR_W'(sel_tail);
  assign ram_raddr = lvl_base + ADDR_W'(sel_head);

  tlpq_ram #(
    .WIDTH (8),
    .DEPTH (RAM_D)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (char_in),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // pointer and count update
  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      head_d[l] = head_q[l];
      tail_d[l] = tail_q[l];
      cnt_d[l]  = cnt_q[l];
      if (sel_lvl == level_t'(l)) begin
        if (ram_we) begin
          tail_d[l] = (tail_q[l] == PTR_LAST) ? '0 : tail_q[l] + 1'b1;
          cnt_d[l]  = cnt_q[l] + 1'b1;
        end
        if (ram_re) begin
          head_d[l] = (head_q[l] == PTR_LAST) ? '0 : head_q[l] + 1'b1;
          cnt_d[l]  = cnt_q[l] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // read stage: request info waits beside the ram read
  always_comb begin
    s1_d.status = req_status;
    s1_d.level  = sel_lvl;
    s1_d.hit    = ram_re;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      s1_q <= s1_d;
    end
  end

  // output register
  always_comb begin
    if (s1_q.hit) begin
      out_char_d = ram_rdata;
    end else if (s1_q.status == ST_EMPTY) begin
      out_char_d = CH_EMPTY;
    end else begin
      out_char_d = CH_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_status_q <= s1_q.status;
      out_char_q   <= out_char_d;
      out_level_q  <= s1_q.level;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_level_q, out_char_q, out_status_q};

  // checks
  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_lvl_chk
    `TLPQ_ASSERT_NEVER(a_cnt_range, cnt_q[g] > CNT_FULL, "fill count above depth")
    `TLPQ_ASSERT(a_ptr_meet, (cnt_q[g] == '0 || cnt_q[g] == CNT_FULL) |-> head_q[g] == tail_q[g], "pointers disagree with fill count")
  end

  `TLPQ_ASSERT(a_adv_out, s1_adv |=> out_valid_q, "advanced result not offered")
  `TLPQ_ASSERT(a_hit_ok, (s1_valid_q && s1_q.hit) |-> s1_q.status == ST_OK, "store read without ok status")

endmodule

// ----- dv/three_level_priority_queue_test.sv -----
// ----------------------------------------------------------------------------
// three_level_priority_queue_test
// Self-checking testbench for the three-level character priority queue.
// Requests are streamed in with random gaps, and results are drained with
// random backpressure. A scoreboard keeps its own three circular fifos,
// predicts each result from the accepted requests, and checks every field
// of the result stream in order.
// ----------------------------------------------------------------------------
module three_level_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpq_pkg::*;

  localparam int DEPTH        = 8;
  localparam int HALF_PERIOD  = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int ITEMS_PER_PH = 367;
  localparam int REPORT_MAX   = 10;
  localparam logic KIND_ENQ   = 1'b0;
  localparam logic KIND_DEQ   = 1'b1;

  typedef logic [$clog2(DEPTH)-1:0] slot_t;

  localparam slot_t SLOT_LAST = slot_t'(DEPTH - 1);

  // result word as packed on m_axis_tdata
  typedef struct packed {
    logic [3:0] pad;
    level_t     level;
    logic [7:0] char_out;
    status_e    status;
  } result_t;

  // predicts queue results and checks them against the result stream
  class tlpq_scoreboard;
    logic [7:0]  slots [NUM_LEVELS][DEPTH];
    slot_t       rd_ptr [NUM_LEVELS];
    slot_t       wr_ptr [NUM_LEVELS];
    int unsigned held [NUM_LEVELS];
    result_t     expected_results [$];
    int          errors;

    function new();
      for (int i = 0; i < NUM_LEVELS; i++) begin
        rd_ptr[i] = '0;
        wr_ptr[i] = '0;
        held[i]   = 0;
      end
      errors = 0;
    endfunction

    // level of a character, lower case folded onto upper case
    function level_t level_of_char(logic [7:0] ch);
      logic [7:0] up;
      up = (ch >= CH_LO_A && ch <= CH_LO_I) ? ch - CASE_OFFSET : ch;
      if (up >= CH_UP_A && up <= CH_UP_C) return LVL_HIGH;
      if (up >= CH_UP_D && up <= CH_UP_F) return LVL_MID;
      if (up >= CH_UP_G && up <= CH_UP_I) return LVL_LOW;
      return LVL_NONE;
    endfunction

    // work out the result of one accepted request
    function void note_request(logic kind, logic [7:0] ch);
      result_t exp;
      level_t  lvl;
      exp = '0;
      exp.status = ST_OK;
      exp.level = LVL_HIGH;
      exp.char_out = CH_NONE;
      if (kind == KIND_ENQ) begin
        lvl = level_of_char(ch);
        if (lvl == LVL_NONE) begin
          exp.status = ST_INVALID;
        end else if (held[lvl] == DEPTH) begin
          exp.status = ST_FULL;
          exp.level = lvl;
        end else begin
          exp.level = lvl;
          slots[lvl][wr_ptr[lvl]] = ch;
          wr_ptr[lvl] = (wr_ptr[lvl] == SLOT_LAST) ? '0 : wr_ptr[lvl] + 1'b1;
          held[lvl]++;
        end
      end else begin
        exp.status = ST_EMPTY;
        exp.char_out = CH_EMPTY;
        // highest non-empty level wins
        for (int i = 0; i < NUM_LEVELS; i++) begin
          if (exp.status == ST_EMPTY && held[i] != 0) begin
            exp.status = ST_OK;
            exp.level = level_t'(i);
            exp.char_out = slots[i][rd_ptr[i]];
            rd_ptr[i] = (rd_ptr[i] == SLOT_LAST) ? '0 : rd_ptr[i] + 1'b1;
            held[i]--;
          end
        end
      end
      expected_results.push_back(exp);
    endfunction

    function void flag(string what, logic [15:0] want, logic [15:0] got);
      errors++;
      if (errors <= REPORT_MAX)
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    endfunction

    // compare one result transfer with the oldest prediction
    function void check_result(logic [15:0] word);
      result_t got;
      result_t exp;
      got = result_t'(word);
      if (expected_results.size() == 0) begin
        flag("unexpected result", 16'h0, word);
        return;
      end
      exp = expected_results.pop_front();
      if (got.status != exp.status)
        flag("status", 16'(exp.status), 16'(got.status));
      if (got.char_out != exp.char_out)
        flag("char_out", 16'(exp.char_out), 16'(got.char_out));
      if (got.level != exp.level)
        flag("level", 16'(exp.level), 16'(got.level));
      if (got.pad != exp.pad)
        flag("upper bits", 16'(exp.pad), 16'(got.pad));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'h00;
  logic        s_axis_tuser_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;

  tlpq_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req    = 0;
  int enq_pct     = 50;

  three_level_priority_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // clock
  always #HALF_PERIOD clk_i = ~clk_i;

  // offer one request and wait for its transfer
  task automatic send_request(logic kind, logic [7:0] ch);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= ch;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_request(kind, ch);
  endtask

  // random request, mostly valid letters, some noise bytes
  task automatic send_random();
    int         pick;
    logic [7:0] ch;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_request(KIND_ENQ, 8'($urandom_range(255)));
    end else if (pick < enq_pct) begin
      ch = CH_UP_A + 8'(3 * $urandom_range(2)) + 8'($urandom_range(2));
      if ($urandom_range(1)) ch = ch + CASE_OFFSET;
      send_request(KIND_ENQ, ch);
    end else begin
      send_request(KIND_DEQ, 8'($urandom_range(255)));
    end
  endtask

  // hold sender until every prediction has been matched
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // result side: check transfers and drive backpressure
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
          idle = 0;
        else
          idle++;
        if (idle >= STALL_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $realtime, idle);
          $display("three_level_priority_queue_test: errors");
          $finish;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [7:0] bad_chars [6];
    logic [7:0] high_chars [8];
    bad_chars  = '{8'h00, 8'hFF, 8'h40, 8'h4A, 8'h60, 8'h6A};
    high_chars = '{CH_UP_A, CH_UP_C, CH_LO_A, CH_UP_C + CASE_OFFSET,
                   CH_UP_A + 8'd1, CH_LO_A + 8'd1, CH_UP_A, CH_UP_C};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty, invalid bytes, range edges, a full level
    send_request(KIND_DEQ, 8'h00);
    foreach (bad_chars[i]) send_request(KIND_ENQ, bad_chars[i]);
    send_request(KIND_ENQ, CH_UP_D);
    send_request(KIND_ENQ, CH_UP_F + CASE_OFFSET);
    send_request(KIND_ENQ, CH_UP_G);
    send_request(KIND_ENQ, CH_LO_I);
    foreach (high_chars[i]) send_request(KIND_ENQ, high_chars[i]);
    send_request(KIND_ENQ, CH_LO_A);
    repeat (5) send_request(KIND_DEQ, 8'hFF);
    wait_drained();

    // random phases with different idling on each side
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 81 : 0;
      rx_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 33 : 0;
      for (int n = 0; n < ITEMS_PER_PH; n++) begin
        // shift the enqueue share so levels fill up and drain
        if (n % 40 == 0) enq_pct = $urandom_range(85, 25);
        if (ph == 0 && n == 100) hold_req++;
        send_random();
      end
      wait_drained();
    end

    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("three_level_priority_queue_test: clean");
    end else begin
      $display("three_level_priority_queue_test: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/tlpq_pkg.sv
hdl/tlpq_ram.sv
hdl/three_level_priority_queue.sv
dv/three_level_priority_queue_test.sv
